[design/kvt_pkg.sv]
// Package for the key-value text tokenizer: event, error and lookahead codes,
// the character constants of the format and the result record between stages.
// No dependencies; imported by every module of the block.
package kvt_pkg;

  // Default for the top-level nesting limit
  localparam int unsigned MAX_DEPTH_DEF = 64;

  // Payload widths fixed by the stream format
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DEPTH_W = 7;

  // Token events
  typedef enum logic [2:0] {
    EV_KEY_CHAR  = 3'd0,
    EV_VAL_CHAR  = 3'd1,
    EV_KEY_DONE  = 3'd2,
    EV_PAIR_DONE = 3'd3,
    EV_SEC_OPEN  = 3'd4,
    EV_SEC_CLOSE = 3'd5,
    EV_ERROR     = 3'd6,
    EV_DOC_END   = 3'd7
  } kvt_event_e;

  // Error and status codes
  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_ILLEGAL_CHAR = 4'd1,
    ERR_BAD_ESCAPE   = 4'd2,
    ERR_NESTED_CMT   = 4'd3,
    ERR_CMT_UNOPENED = 4'd4,
    ERR_NO_NAME      = 4'd5,
    ERR_CLOSE_KEY    = 4'd6,
    ERR_CLOSE_TOP    = 4'd7,
    ERR_DEPTH_OVF    = 4'd8,
    ERR_OPEN_CMT     = 4'd9
  } kvt_err_e;

  // Byte held as lookahead until the next byte
  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_SLASH  = 2'd1,
    PEND_STAR   = 2'd2,
    PEND_BSLASH = 2'd3
  } kvt_pend_e;

  // Characters of the format
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // One token event as it travels to the output register
  typedef struct packed {
    kvt_event_e           evt;
    logic [BYTE_W-1:0]    chr;
    logic [DEPTH_W-1:0]   depth;
    kvt_err_e             code;
  } kvt_result_t;

  // Space, tab, LF, VT, FF, CR
  function automatic logic kvt_is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

[design/kvt_step.sv]
// Tokenizer state and the single-pass decode of one document byte.
// Depends on kvt_pkg; instantiated by keyvalue_text_tokenizer.
module kvt_step
  import kvt_pkg::*;
#(
  parameter int unsigned MaxDepth = MAX_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_vld_i,
  input  logic              item_end_i,
  input  logic [7:0]        item_byte_i,
  output logic              res_vld_o,
  output kvt_result_t       res_o
);

  localparam int unsigned LvlW = $clog2(MaxDepth + 1);

  logic            quotes_q, quotes_d;
  logic            line_cmt_q, line_cmt_d;
  logic            blk_cmt_q, blk_cmt_d;
  logic            chew_q, chew_d;
  kvt_pend_e       pend_q, pend_d;
  logic            key_q, key_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  kvt_err_e        err_q, err_d;

  logic            chew_now;
  logic            is_ws;
  logic            doc_end;
  kvt_event_e      char_ev;

  assign is_ws   = kvt_is_ws(item_byte_i);
  assign doc_end = item_end_i || (item_byte_i == CH_NUL);
  assign char_ev = key_q ? EV_VAL_CHAR : EV_KEY_CHAR;

  // Next state and result for the byte in the input register
  always_comb begin
    quotes_d   = quotes_q;
    line_cmt_d = line_cmt_q;
    blk_cmt_d  = blk_cmt_q;
    chew_d     = chew_q;
    pend_d     = pend_q;
    key_d      = key_q;
    lvl_d      = lvl_q;
    err_d      = err_q;
    chew_now   = chew_q | (item_byte_i == CH_LF);
    res_vld_o  = 1'b0;
    res_o.evt  = EV_KEY_CHAR;
    res_o.chr  = CH_NUL;
    res_o.code = ERR_NONE;

    if (item_vld_i) begin
      if (item_end_i || (item_byte_i == CH_NUL)) begin
        // Document end: report status, then back to reset state
        res_vld_o = 1'b1;
        res_o.evt = EV_DOC_END;
        if (err_q != ERR_NONE) begin
          res_o.code = err_q;
        end else if (pend_q == PEND_BSLASH) begin
          res_o.code = ERR_BAD_ESCAPE;
        end else if (blk_cmt_q) begin
          res_o.code = ERR_OPEN_CMT;
        end else if (pend_q != PEND_NONE) begin
          res_o.code = ERR_ILLEGAL_CHAR;
        end
        quotes_d   = 1'b0;
        line_cmt_d = 1'b0;
        blk_cmt_d  = 1'b0;
        chew_d     = 1'b0;
        pend_d     = PEND_NONE;
        key_d      = 1'b0;
        lvl_d      = '0;
        err_d      = ERR_NONE;
      end else if (err_q != ERR_NONE) begin
        // parse stopped until the end item
      end else if (quotes_q) begin
        if (pend_q == PEND_BSLASH) begin
          // Escape sequence
          pend_d    = PEND_NONE;
          res_vld_o = 1'b1;
          res_o.evt = char_ev;
          case (item_byte_i)
            CH_LC_R:  res_o.chr = CH_CR;
            CH_LC_N:  res_o.chr = CH_LF;
            CH_LC_T:  res_o.chr = CH_TAB;
            CH_QUOTE, CH_APOS, CH_BSLASH: res_o.chr = item_byte_i;
            default: begin
              res_o.evt  = EV_ERROR;
              res_o.code = ERR_BAD_ESCAPE;
              err_d      = ERR_BAD_ESCAPE;
            end
          endcase
        end else if (chew_now && is_ws) begin
          chew_d = 1'b1;
        end else begin
          chew_d = 1'b0;
          if (item_byte_i == CH_BSLASH) begin
            pend_d = PEND_BSLASH;
          end else if (item_byte_i == CH_QUOTE) begin
            quotes_d  = 1'b0;
            key_d     = ~key_q;
            res_vld_o = 1'b1;
            res_o.evt = key_q ? EV_PAIR_DONE : EV_KEY_DONE;
          end else begin
            res_vld_o = 1'b1;
            res_o.evt = char_ev;
            res_o.chr = item_byte_i;
          end
        end
      end else if (line_cmt_q) begin
        if (item_byte_i == CH_LF) begin
          line_cmt_d = 1'b0;
        end
      end else if (blk_cmt_q) begin
        // Inside a block comment only the openers and closers matter
        if ((pend_q == PEND_SLASH) && (item_byte_i == CH_STAR)) begin
          res_vld_o  = 1'b1;
          res_o.evt  = EV_ERROR;
          res_o.code = ERR_NESTED_CMT;
          err_d      = ERR_NESTED_CMT;
        end else if ((pend_q == PEND_STAR) && (item_byte_i == CH_SLASH)) begin
          pend_d    = PEND_NONE;
          blk_cmt_d = 1'b0;
        end else if (item_byte_i == CH_SLASH) begin
          pend_d = PEND_SLASH;
        end else if (item_byte_i == CH_STAR) begin
          pend_d = PEND_STAR;
        end else begin
          pend_d = PEND_NONE;
        end
      end else if (pend_q == PEND_SLASH) begin
        pend_d = PEND_NONE;
        if (item_byte_i == CH_SLASH) begin
          line_cmt_d = 1'b1;
        end else if (item_byte_i == CH_STAR) begin
          blk_cmt_d = 1'b1;
        end else begin
          res_vld_o  = 1'b1;
          res_o.evt  = EV_ERROR;
          res_o.code = ERR_ILLEGAL_CHAR;
          err_d      = ERR_ILLEGAL_CHAR;
        end
      end else if (pend_q == PEND_STAR) begin
        pend_d     = PEND_NONE;
        res_vld_o  = 1'b1;
        res_o.evt  = EV_ERROR;
        res_o.code = (item_byte_i == CH_SLASH) ? ERR_CMT_UNOPENED : ERR_ILLEGAL_CHAR;
        err_d      = res_o.code;
      end else begin
        // Plain text between tokens
        pend_d = PEND_NONE;
        case (item_byte_i)
          CH_QUOTE: begin
            quotes_d = 1'b1;
            chew_d   = 1'b0;
          end
          CH_LBRACE: begin
            res_vld_o = 1'b1;
            if (!key_q) begin
              res_o.evt  = EV_ERROR;
              res_o.code = ERR_NO_NAME;
              err_d      = ERR_NO_NAME;
            end else if (lvl_q >= LvlW'(MaxDepth)) begin
              res_o.evt  = EV_ERROR;
              res_o.code = ERR_DEPTH_OVF;
              err_d      = ERR_DEPTH_OVF;
            end else begin
              lvl_d     = lvl_q + 1'b1;
              key_d     = 1'b0;
              res_o.evt = EV_SEC_OPEN;
            end
          end
          CH_RBRACE: begin
            res_vld_o = 1'b1;
            if (key_q) begin
              res_o.evt  = EV_ERROR;
              res_o.code = ERR_CLOSE_KEY;
              err_d      = ERR_CLOSE_KEY;
            end else if (lvl_q == '0) begin
              res_o.evt  = EV_ERROR;
              res_o.code = ERR_CLOSE_TOP;
              err_d      = ERR_CLOSE_TOP;
            end else begin
              lvl_d     = lvl_q - 1'b1;
              res_o.evt = EV_SEC_CLOSE;
            end
          end
          CH_SLASH: pend_d = PEND_SLASH;
          CH_STAR:  pend_d = PEND_STAR;
          default: begin
            if (item_byte_i == CH_LF) begin
              chew_d = 1'b0;
            end
            if (!is_ws) begin
              res_vld_o  = 1'b1;
              res_o.evt  = EV_ERROR;
              res_o.code = ERR_ILLEGAL_CHAR;
              err_d      = ERR_ILLEGAL_CHAR;
            end
          end
        endcase
      end
    end

    // Depth reported is the level after this event; end reports the level before reset
    res_o.depth = doc_end ? DEPTH_W'(lvl_q) : DEPTH_W'(lvl_d);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quotes_q   <= 1'b0;
      line_cmt_q <= 1'b0;
      blk_cmt_q  <= 1'b0;
      chew_q     <= 1'b0;
      pend_q     <= PEND_NONE;
      key_q      <= 1'b0;
      lvl_q      <= '0;
      err_q      <= ERR_NONE;
    end else begin
      quotes_q   <= quotes_d;
      line_cmt_q <= line_cmt_d;
      blk_cmt_q  <= blk_cmt_d;
      chew_q     <= chew_d;
      pend_q     <= pend_d;
      key_q      <= key_d;
      lvl_q      <= lvl_d;
      err_q      <= err_d;
    end
  end

endmodule

[design/kvt_out_stage.sv]
// Output register of the tokenizer: holds one token event for the receiver
// and tells the upstream stage when it may hand over the next one.
// Depends on kvt_pkg; instantiated by keyvalue_text_tokenizer.
module kvt_out_stage
  import kvt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_vld_i,
  input  kvt_result_t res_i,
  output logic        can_take_o,
  output logic        out_vld_o,
  input  logic        out_rdy_i,
  output kvt_result_t out_o
);

  logic        vld_q;
  kvt_result_t data_q;

  // Free when empty or being drained this cycle
  assign can_take_o = !vld_q || out_rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (can_take_o) begin
      vld_q <= res_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take_o && res_vld_i) begin
      data_q <= res_i;
    end
  end

  assign out_vld_o = vld_q;
  assign out_o     = data_q;

endmodule

[design/keyvalue_text_tokenizer.sv]
// Top level of the key-value text tokenizer: input register, step logic
// and output register. Depends on kvt_pkg, kvt_step and kvt_out_stage.
//
// Usage:
//   s_axis carries the document: tdata is one text byte, tuser marks the
//   end-of-document item (tdata is then ignored). A zero byte also ends the
//   document. m_axis carries token events: tuser is the event kind, tdata
//   holds the decoded character, the nesting depth after the event and the
//   error or status code.
//   Each byte causes zero or one event. An accepted item waits in the input
//   register and passes through the step logic into the output register once
//   that register has room; its event is then shown on m_axis. The block takes
//   one byte every cycle as long as the receiver keeps up; the figure is set
//   by the single pass from the input register through the step logic into
//   the output register. When the receiver stalls with an event held, the
//   input register fills and s_axis_tready drops until the event is taken.
//   Reset empties both registers and puts the tokenizer at the start of a
//   document with depth zero; every end-of-document item does the same after
//   reporting its status. After the first error, bytes give no events until
//   the end item.
module keyvalue_text_tokenizer
  import kvt_pkg::*;
#(
  parameter int unsigned MaxDepth = MAX_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] char_out, [14:8] depth, [18:15] error_code
  output logic [2:0]  m_axis_tuser    // [2:0] event_res
);

  logic        in_vld_q;
  logic        in_end_q;
  logic [7:0]  in_byte_q;
  logic        advance;
  logic        can_take;
  logic        res_vld;
  kvt_result_t res;
  kvt_result_t out_res;

  // Input register moves on whenever the output register has room
  assign advance       = in_vld_q && can_take;
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_end_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  kvt_step #(
    .MaxDepth (MaxDepth)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_vld_i  (advance),
    .item_end_i  (in_end_q),
    .item_byte_i (in_byte_q),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  kvt_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_vld_i  (res_vld),
    .res_i      (res),
    .can_take_o (can_take),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_o      (out_res)
  );

  // Pack the result onto the stream
  assign m_axis_tuser = out_res.evt;
  assign m_axis_tdata = {5'b0, out_res.code, out_res.depth, out_res.chr};

endmodule

[design/kvt_checker.sv]
// Port-level checks for the key-value text tokenizer, bound to its top level.
// Depends on kvt_pkg and keyvalue_text_tokenizer.
module kvt_checker
  import kvt_pkg::*;
#(
  parameter int unsigned MaxDepth = MAX_DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic [7:0] chr;
  logic [6:0] dep;
  logic [3:0] code;

  assign chr  = m_axis_tdata[7:0];
  assign dep  = m_axis_tdata[14:8];
  assign code = m_axis_tdata[18:15];

  // A stalled event holds still
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("event changed while stalled");

  // An error event always names its error
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_ERROR) |-> (code != ERR_NONE) && (chr == CH_NUL))
    else $error("error event without code");

  // Token events other than error and end carry no code
  a_ok_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != EV_ERROR) && (m_axis_tuser != EV_DOC_END)
      |-> (code == ERR_NONE))
    else $error("code on a plain token event");

  // Reported depth never passes the limit
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(dep) <= 32'(MaxDepth)))
    else $error("depth beyond limit");

endmodule

bind keyvalue_text_tokenizer kvt_checker #(
  .MaxDepth (MaxDepth)
) u_kvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
